// ----- rtl/core/bed_pkg.sv -----
// shared types, character codes and helper functions for the backslash escape decoder
// used by bed_decode and backslash_escape_decoder; depends on nothing else
package bed_pkg;

	localparam int MaxResults = 4;
	localparam int CountW     = $clog2(MaxResults + 1);

	// decode state codes
	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_BEGIN  = 2'd1,
		MODE_OCTAL  = 2'd2,
		MODE_HEX    = 2'd3
	} mode_t;

	// configuration register indexes
	localparam logic CFG_ESCAPE_ENABLE  = 1'b0;
	localparam logic CFG_APPEND_NEWLINE = 1'b1;

	localparam logic [1:0] OctMaxDigits = 2'd3;
	localparam logic [1:0] HexMaxDigits = 2'd2;

	localparam logic [7:0] ChBackslash = 8'h5C;
	localparam logic [7:0] ChZero      = 8'h30;
	localparam logic [7:0] ChSeven     = 8'h37;
	localparam logic [7:0] ChNine      = 8'h39;
	localparam logic [7:0] ChUpperA    = 8'h41;
	localparam logic [7:0] ChUpperF    = 8'h46;
	localparam logic [7:0] ChLowerA    = 8'h61;
	localparam logic [7:0] ChLowerF    = 8'h66;
	localparam logic [7:0] ChLowerX    = 8'h78;
	localparam logic [7:0] ChNewline   = 8'h0A;

	typedef struct packed {
		logic escape_enable;
		logic append_newline;
	} cfg_t;

	typedef struct packed {
		mode_t      mode;
		logic [1:0] digits;
		logic [7:0] pending;
	} dec_state_t;

	typedef struct packed {
		logic [MaxResults-1:0][7:0] bytes;
		logic [CountW-1:0]          count;
		logic                       last;
	} dec_result_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] code;
	} esc_code_t;

	function automatic logic is_oct(input logic [7:0] c);
		return (c >= ChZero) && (c <= ChSeven);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= ChZero) && (c <= ChNine)) || ((c >= ChUpperA) && (c <= ChUpperF))
			|| ((c >= ChLowerA) && (c <= ChLowerF));
	endfunction

	// letters map to 10..15 in either case
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		return (c <= ChNine) ? c[3:0] : c[3:0] + 4'd9;
	endfunction

	// single character escapes
	function automatic esc_code_t esc_lookup(input logic [7:0] c);
		esc_code_t r;
		r.hit = 1'b1;
		unique case (c)
			8'h5C: r.code = 8'h5C; // backslash
			8'h61: r.code = 8'h07; // a
			8'h62: r.code = 8'h08; // b
			8'h65: r.code = 8'h1B; // e
			8'h66: r.code = 8'h0C; // f
			8'h6E: r.code = 8'h0A; // n
			8'h72: r.code = 8'h0D; // r
			8'h74: r.code = 8'h09; // t
			8'h76: r.code = 8'h0B; // v
			default: begin
				r.hit  = 1'b0;
				r.code = 8'h00;
			end
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/bed_decode.sv -----
// per-byte escape decode: next state and up to four output bytes for one input byte
// depends on bed_pkg
module bed_decode (
	input  bed_pkg::cfg_t        cfg,
	input  bed_pkg::dec_state_t  state,
	input  logic [7:0]           in_char,
	input  logic                 in_last,
	output bed_pkg::dec_state_t  next_state,
	output bed_pkg::dec_result_t result
);

	always_comb begin
		bed_pkg::dec_state_t ns;
		bed_pkg::dec_result_t r;
		bed_pkg::esc_code_t esc;
		logic [bed_pkg::CountW-1:0] n;
		logic plain;
		logic [1:0] dnext;
		logic [7:0] pnext;

		ns    = state;
		r     = '0;
		n     = '0;
		plain = 1'b0;
		esc   = bed_pkg::esc_lookup(in_char);
		dnext = state.digits + 2'd1;
		pnext = '0;

		if (!cfg.escape_enable) begin
			r.bytes[n[1:0]] = in_char;
			n = n + 1'b1;
		end else begin
			unique case (state.mode)
				bed_pkg::MODE_NORMAL: plain = 1'b1;
				bed_pkg::MODE_BEGIN: begin
					ns = '0;
					if (in_char == bed_pkg::ChZero) begin
						ns.mode = bed_pkg::MODE_OCTAL;
					end else if (in_char == bed_pkg::ChLowerX) begin
						ns.mode = bed_pkg::MODE_HEX;
					end else if (esc.hit) begin
						r.bytes[n[1:0]] = esc.code;
						n = n + 1'b1;
					end else begin
						// unknown escape keeps both bytes
						r.bytes[n[1:0]] = bed_pkg::ChBackslash;
						n = n + 1'b1;
						r.bytes[n[1:0]] = in_char;
						n = n + 1'b1;
					end
				end
				bed_pkg::MODE_OCTAL: begin
					if (bed_pkg::is_oct(in_char) && state.digits < bed_pkg::OctMaxDigits) begin
						pnext = {state.pending[4:0], in_char[2:0]};
						ns.pending = pnext;
						ns.digits  = dnext;
						if (dnext == bed_pkg::OctMaxDigits) begin
							r.bytes[n[1:0]] = pnext;
							n = n + 1'b1;
							ns = '0;
						end
					end else begin
						r.bytes[n[1:0]] = state.pending;
						n = n + 1'b1;
						ns = '0;
						plain = 1'b1;
					end
				end
				bed_pkg::MODE_HEX: begin
					if (bed_pkg::is_hex(in_char) && state.digits < bed_pkg::HexMaxDigits) begin
						pnext = {state.pending[3:0], bed_pkg::hex_value(in_char)};
						ns.pending = pnext;
						ns.digits  = dnext;
						if (dnext == bed_pkg::HexMaxDigits) begin
							r.bytes[n[1:0]] = pnext;
							n = n + 1'b1;
							ns = '0;
						end
					end else begin
						if (state.digits == 2'd0) begin
							// no digits: give back the escape text
							r.bytes[n[1:0]] = bed_pkg::ChBackslash;
							n = n + 1'b1;
							r.bytes[n[1:0]] = bed_pkg::ChLowerX;
							n = n + 1'b1;
						end else begin
							r.bytes[n[1:0]] = state.pending;
							n = n + 1'b1;
						end
						ns = '0;
						plain = 1'b1;
					end
				end
				default: ns = '0;
			endcase

			// byte that ends an escape is decoded as ordinary input
			if (plain) begin
				if (in_char == bed_pkg::ChBackslash) begin
					ns.mode = bed_pkg::MODE_BEGIN;
				end else begin
					r.bytes[n[1:0]] = in_char;
					n = n + 1'b1;
				end
			end
		end

		if (in_last) begin
			if (cfg.escape_enable) begin
				unique case (ns.mode)
					bed_pkg::MODE_NORMAL: ;
					bed_pkg::MODE_BEGIN: begin
						r.bytes[n[1:0]] = bed_pkg::ChBackslash;
						n = n + 1'b1;
					end
					bed_pkg::MODE_OCTAL: begin
						r.bytes[n[1:0]] = ns.pending;
						n = n + 1'b1;
					end
					bed_pkg::MODE_HEX: begin
						if (ns.digits == 2'd0) begin
							r.bytes[n[1:0]] = bed_pkg::ChBackslash;
							n = n + 1'b1;
							r.bytes[n[1:0]] = bed_pkg::ChLowerX;
							n = n + 1'b1;
						end else begin
							r.bytes[n[1:0]] = ns.pending;
							n = n + 1'b1;
						end
					end
					default: ;
				endcase
			end
			ns = '0;
			if (cfg.append_newline) begin
				r.bytes[n[1:0]] = bed_pkg::ChNewline;
				n = n + 1'b1;
			end
		end

		r.count    = n;
		r.last     = in_last;
		next_state = ns;
		result     = r;
	end

endmodule

// ----- rtl/core/backslash_escape_decoder.sv -----
// top level of the backslash escape decoder: handshakes, state and result buffer
// depends on bed_pkg and bed_decode
//
// usage
// - s_axis carries one message byte per transaction, s_axis_tlast on the final byte
// - m_axis carries decoded bytes, m_axis_tlast on the final output byte of a message
// - each input byte is decoded in the cycle it is taken; its 0 to 4 output bytes land
//   in a four-entry result buffer and appear on m_axis from the next cycle on
// - throughput: one input byte per cycle while each byte gives at most one output
//   byte and the receiver is ready; a byte that gives k > 1 output bytes holds
//   s_axis_tready low while the buffer drains, one byte per cycle when the receiver is ready
// - s_axis_tready is high when the buffer is empty or its last byte leaves this cycle
// - when the receiver stalls the buffer holds, m_axis_tdata stays put and no new
//   input is taken while the buffer has any byte left to send
// - config: cfg_we writes cfg_wdata into register cfg_index (0 escape_enable,
//   1 append_newline); write only while the block is idle
// - reset: escapes off, newline append on, decode state normal, buffer empty
module backslash_escape_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic       cfg_wdata,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_char
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_char
	output logic       m_axis_tlast
);

	bed_pkg::cfg_t        cfg_q;
	bed_pkg::dec_state_t  state_q;
	bed_pkg::dec_state_t  next_state;
	bed_pkg::dec_result_t dec;

	// result buffer, entry 0 is the head
	logic [bed_pkg::MaxResults-1:0][7:0] buf_q;
	logic [bed_pkg::CountW-1:0]          rem_q;
	logic                                last_q;

	logic in_fire;
	logic out_fire;

	assign m_axis_tvalid = (rem_q != '0);
	assign m_axis_tdata  = buf_q[0];
	// last flag belongs to the final byte of the buffer
	assign m_axis_tlast  = last_q && (rem_q == bed_pkg::CountW'(1));
	assign out_fire      = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (rem_q == '0) || ((rem_q == bed_pkg::CountW'(1)) && m_axis_tready);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	bed_decode u_decode (
		.cfg        (cfg_q),
		.state      (state_q),
		.in_char    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.next_state (next_state),
		.result     (dec)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.escape_enable  <= 1'b0;
			cfg_q.append_newline <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bed_pkg::CFG_ESCAPE_ENABLE:  cfg_q.escape_enable  <= cfg_wdata;
				bed_pkg::CFG_APPEND_NEWLINE: cfg_q.append_newline <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// decode state advances once per input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_fire) begin
			state_q <= next_state;
		end
	end

	// buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			last_q <= 1'b0;
		end else if (in_fire) begin
			rem_q  <= dec.count;
			last_q <= dec.last;
		end else if (out_fire) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	// buffer payload, shifts toward the head as bytes leave
	always_ff @(posedge clk) begin
		if (in_fire) begin
			buf_q <= dec.bytes;
		end else if (out_fire) begin
			buf_q <= {8'h00, buf_q[bed_pkg::MaxResults-1:1]};
		end
	end

`ifndef SYNTH
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= bed_pkg::CountW'(bed_pkg::MaxResults))
		else $error("result buffer count out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> (rem_q == '0) || (out_fire && rem_q == bed_pkg::CountW'(1)))
		else $error("input taken while undelivered bytes remain");

	a_result_shows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (dec.count != '0) |=> m_axis_tvalid && (rem_q == $past(dec.count)))
		else $error("decoded bytes not presented");

	a_state_idle_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && s_axis_tlast |=> (state_q == '0))
		else $error("decode state not cleared at end of message");

	a_drain_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !in_fire |=> rem_q == $past(rem_q) - 1'b1)
		else $error("buffer count did not step down");
`endif

endmodule

// ----- dv/escape_decode_checker.sv -----
// checker for the backslash escape decoder: watches the config port and both streams
// predicts decoded bytes per input transaction and compares them in order; needs bed_pkg
module escape_decode_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic       cfg_wdata,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	input  logic       m_tlast,
	input  logic       drain_check,
	output int         expected_count,
	output int         fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PrintCap = 50;

	// escape letters and the control codes they stand for
	localparam logic [7:0] LetB = 8'h62;
	localparam logic [7:0] LetE = 8'h65;
	localparam logic [7:0] LetN = 8'h6E;
	localparam logic [7:0] LetR = 8'h72;
	localparam logic [7:0] LetT = 8'h74;
	localparam logic [7:0] LetV = 8'h76;
	localparam logic [7:0] CodeBell = 8'h07;
	localparam logic [7:0] CodeBack = 8'h08;
	localparam logic [7:0] CodeTab  = 8'h09;
	localparam logic [7:0] CodeVtab = 8'h0B;
	localparam logic [7:0] CodeFeed = 8'h0C;
	localparam logic [7:0] CodeCret = 8'h0D;
	localparam logic [7:0] CodeEsc  = 8'h1B;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} out_byte_t;

	out_byte_t  decoded_q[$];
	logic [7:0] step_q[$];

	logic             cfg_escape;
	logic             cfg_newline;
	bed_pkg::mode_t   mode;
	logic [1:0]       digits;
	logic [7:0]       pending;
	logic             drain_done;

	task automatic report_mismatch(input string what);
		if (fail_count < PrintCap)
			$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	function automatic void emit_byte(input logic [7:0] c);
		if (step_q.size() < bed_pkg::MaxResults)
			step_q = {step_q, c};
	endfunction

	function automatic void go_normal();
		mode    = bed_pkg::MODE_NORMAL;
		digits  = 2'd0;
		pending = 8'd0;
	endfunction

	// bit 4 flags a hex digit, low nibble holds its value
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= bed_pkg::ChZero && c <= bed_pkg::ChNine)
			return {1'b1, c[3:0]};
		if (c >= bed_pkg::ChUpperA && c <= bed_pkg::ChUpperF) begin
			v = c - bed_pkg::ChUpperA + 8'd10;
			return {1'b1, v[3:0]};
		end
		if (c >= bed_pkg::ChLowerA && c <= bed_pkg::ChLowerF) begin
			v = c - bed_pkg::ChLowerA + 8'd10;
			return {1'b1, v[3:0]};
		end
		return 5'd0;
	endfunction

	function automatic void take_plain(input logic [7:0] c);
		if (c == bed_pkg::ChBackslash)
			mode = bed_pkg::MODE_BEGIN;
		else
			emit_byte(c);
	endfunction

	function automatic void begin_escape(input logic [7:0] c);
		go_normal();
		case (c)
			bed_pkg::ChZero:      mode = bed_pkg::MODE_OCTAL;
			bed_pkg::ChLowerX:    mode = bed_pkg::MODE_HEX;
			bed_pkg::ChBackslash: emit_byte(bed_pkg::ChBackslash);
			bed_pkg::ChLowerA:    emit_byte(CodeBell);
			LetB:                 emit_byte(CodeBack);
			LetE:                 emit_byte(CodeEsc);
			bed_pkg::ChLowerF:    emit_byte(CodeFeed);
			LetN:                 emit_byte(bed_pkg::ChNewline);
			LetR:                 emit_byte(CodeCret);
			LetT:                 emit_byte(CodeTab);
			LetV:                 emit_byte(CodeVtab);
			default: begin
				// unknown escape goes out verbatim
				emit_byte(bed_pkg::ChBackslash);
				emit_byte(c);
			end
		endcase
	endfunction

	function automatic void decode_char(input logic [7:0] c);
		logic [4:0] nib;
		nib = hex_nibble(c);
		case (mode)
			bed_pkg::MODE_NORMAL: take_plain(c);
			bed_pkg::MODE_BEGIN:  begin_escape(c);
			bed_pkg::MODE_OCTAL: begin
				if (c >= bed_pkg::ChZero && c <= bed_pkg::ChSeven
					&& digits < bed_pkg::OctMaxDigits) begin
					pending = {pending[4:0], c[2:0]};
					digits  = digits + 2'd1;
					if (digits >= bed_pkg::OctMaxDigits) begin
						emit_byte(pending);
						go_normal();
					end
				end else begin
					emit_byte(pending);
					go_normal();
					take_plain(c);
				end
			end
			default: begin
				if (nib[4] && digits < bed_pkg::HexMaxDigits) begin
					pending = {pending[3:0], nib[3:0]};
					digits  = digits + 2'd1;
					if (digits >= bed_pkg::HexMaxDigits) begin
						emit_byte(pending);
						go_normal();
					end
				end else begin
					if (digits == 2'd0) begin
						emit_byte(bed_pkg::ChBackslash);
						emit_byte(bed_pkg::ChLowerX);
					end else begin
						emit_byte(pending);
					end
					go_normal();
					take_plain(c);
				end
			end
		endcase
	endfunction

	function automatic void flush_escape();
		case (mode)
			bed_pkg::MODE_BEGIN: emit_byte(bed_pkg::ChBackslash);
			bed_pkg::MODE_OCTAL: emit_byte(pending);
			bed_pkg::MODE_HEX: begin
				if (digits == 2'd0) begin
					emit_byte(bed_pkg::ChBackslash);
					emit_byte(bed_pkg::ChLowerX);
				end else begin
					emit_byte(pending);
				end
			end
			default: ;
		endcase
		go_normal();
	endfunction

	task automatic predict_decode(input logic [7:0] c, input logic is_final);
		out_byte_t item;
		step_q.delete();
		if (cfg_escape)
			decode_char(c);
		else
			emit_byte(c);
		if (is_final) begin
			if (cfg_escape)
				flush_escape();
			else
				go_normal();
			if (cfg_newline)
				emit_byte(bed_pkg::ChNewline);
		end
		foreach (step_q[i]) begin
			item.ch   = step_q[i];
			item.last = is_final && (i == step_q.size() - 1);
			decoded_q = {decoded_q, item};
		end
	endtask

	task automatic check_output();
		out_byte_t want;
		if (decoded_q.size() == 0) begin
			report_mismatch($sformatf("byte 0x%02h last %0b with nothing expected",
				m_tdata, m_tlast));
		end else begin
			want = decoded_q.pop_front();
			if (m_tdata !== want.ch)
				report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
					m_tdata, want.ch));
			if (m_tlast !== want.last)
				report_mismatch($sformatf("out_last %0b, expected %0b on byte 0x%02h",
					m_tlast, want.last, want.ch));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_escape  = 1'b0;
			cfg_newline = 1'b1;
			drain_done  = 1'b0;
			fail_count  = 0;
			go_normal();
			decoded_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == bed_pkg::CFG_ESCAPE_ENABLE)
					cfg_escape = cfg_wdata;
				else
					cfg_newline = cfg_wdata;
			end
			if (m_tvalid && m_tready)
				check_output();
			if (s_tvalid && s_tready)
				predict_decode(s_tdata, s_tlast);
			// end of run: anything still owed never arrived
			if (drain_check && !drain_done) begin
				drain_done = 1'b1;
				if (decoded_q.size() != 0)
					report_mismatch($sformatf("%0d decoded bytes never arrived",
						decoded_q.size()));
			end
		end
		expected_count = decoded_q.size();
	end

endmodule

// ----- dv/tb.sv -----
// top of the backslash escape decoder testbench: clock, reset, stimulus and verdict
// depends on bed_pkg, backslash_escape_decoder and escape_decode_checker
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// consecutive cycles without any transaction before the run is declared hung
	localparam int StallLimit = 2000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'd0;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic       drain_check = 1'b0;

	int pending_bytes;
	int fail_count;
	int items_sent = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int stall_cycles = 0;

	logic [7:0] msg[$];

	always #2 clk = ~clk;

	backslash_escape_decoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),  // [7:0] in_char
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),  // [7:0] out_char
		.m_axis_tlast (m_axis_tlast)
	);

	escape_decode_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_axis_tvalid),
		.s_tready      (s_axis_tready),
		.s_tdata       (s_axis_tdata),
		.s_tlast       (s_axis_tlast),
		.m_tvalid      (m_axis_tvalid),
		.m_tready      (m_axis_tready),
		.m_tdata       (m_axis_tdata),
		.m_tlast       (m_axis_tlast),
		.drain_check   (drain_check),
		.expected_count(pending_bytes),
		.fail_count    (fail_count)
	);

	// receiver backpressure, redrawn every cycle at the falling edge
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// hang detection: any transaction on either stream resets the count
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= StallLimit) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// config writes happen one cycle at a time with the streams idle
	task automatic write_reg(input logic idx, input logic val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	// drop tvalid and let every predicted byte come out
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_bytes != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// one input transaction, with random sender gaps in front of it
	task automatic send_byte(input logic [7:0] c, input logic is_final);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= is_final;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// sends the assembled message, tlast on its final byte
	task automatic send_message();
		foreach (msg[i])
			send_byte(msg[i], i == msg.size() - 1);
		msg.delete();
	endtask

	// appends one byte to the message under construction
	function automatic void add_byte(input logic [7:0] c);
		msg = {msg, c};
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	// one random escape token or plain byte; mostly well-formed escapes with random
	// content, plus stray backslashes, unknown escapes and digit runs past the limit
	task automatic add_token();
		string letters = "abefnrtv\\";
		string octs    = "01234567";
		string hexes   = "0123456789abcdefABCDEF";
		int    n;
		case ($urandom_range(9))
			0, 1: add_byte(8'($urandom_range(255)));
			2: begin
				add_byte(bed_pkg::ChBackslash);
				add_byte(letters[$urandom_range(letters.len() - 1)]);
			end
			3, 4: begin
				// octal with zero to four digits, the fourth lands as plain text
				add_byte(bed_pkg::ChBackslash);
				add_byte(bed_pkg::ChZero);
				n = $urandom_range(4);
				repeat (n) add_byte(octs[$urandom_range(7)]);
			end
			5, 6: begin
				// hex with zero to three digits, either case
				add_byte(bed_pkg::ChBackslash);
				add_byte(bed_pkg::ChLowerX);
				n = $urandom_range(3);
				repeat (n) add_byte(hexes[$urandom_range(hexes.len() - 1)]);
			end
			7: begin
				// backslash followed by anything, mostly unknown escapes
				add_byte(bed_pkg::ChBackslash);
				add_byte(8'($urandom_range(255)));
			end
			8: add_byte(8'($urandom_range(8'h30, 8'h7A)));
			default: add_byte(bed_pkg::ChBackslash);
		endcase
	endtask

	// random messages until the item count reaches the target
	task automatic run_random(input int target);
		int tokens;
		while (items_sent < target) begin
			tokens = $urandom_range(1, 6);
			repeat (tokens) add_token();
			send_message();
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// phase one: sender idles lightly, receiver heavily
		tx_idle_pct = 27;
		rx_idle_pct = 53;

		// reset config passes bytes through and appends a newline;
		// extreme byte values and a backslash with nothing to escape
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(bed_pkg::ChBackslash);
		send_message();
		wait_idle();

		write_reg(bed_pkg::CFG_ESCAPE_ENABLE, 1'b1);
		// every single-character escape
		add_text("\\a\\b\\e\\f\\n\\r\\t\\v\\\\");
		send_message();
		// octal hitting its digit limit and wrapping, two-digit hex in mixed case,
		// an unknown escape and a backslash left dangling at the end of the message
		add_text("\\0777\\xFf\\q\\");
		send_message();
		run_random(130);
		wait_idle();

		// phase two: sender idles heavily, receiver lightly, no trailing newline
		tx_idle_pct = 53;
		rx_idle_pct = 27;
		write_reg(bed_pkg::CFG_APPEND_NEWLINE, 1'b0);
		run_random(190);
		// hold the sender until the output side has fully drained
		wait_idle();
		run_random(250);
		wait_idle();

		// phase three: no idling at all
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_reg(bed_pkg::CFG_ESCAPE_ENABLE, 1'b0);
		write_reg(bed_pkg::CFG_APPEND_NEWLINE, 1'b1);
		run_random(290);
		wait_idle();
		write_reg(bed_pkg::CFG_APPEND_NEWLINE, 1'b0);
		run_random(320);
		wait_idle();
		write_reg(bed_pkg::CFG_ESCAPE_ENABLE, 1'b1);
		write_reg(bed_pkg::CFG_APPEND_NEWLINE, 1'b1);
		run_random(380);

		// wait for the tail, then let the checker flag anything still owed
		wait_idle();
		repeat (8) @(negedge clk);
		drain_check <= 1'b1;
		@(negedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
